// ===== hdl/light_bar_pair_matcher_defines.svh =====
// Assertion macros shared by the light-bar pair matcher RTL.
// Depends on nothing; users must have clk and rst_n in scope.
`ifndef LIGHT_BAR_PAIR_MATCHER_DEFINES_SVH
`define LIGHT_BAR_PAIR_MATCHER_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define LBPM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lbpm assertion failed");
// next-cycle implication
`define LBPM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lbpm assertion failed");
`else
`define LBPM_ASSERT_IMP(lbl, ante, cons)
`define LBPM_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== hdl/lbpm_pkg.sv =====
// Package for the light-bar pair matcher: payload types, constants, states.
// No dependencies.
package lbpm_pkg;

  localparam int MAX_BARS_DEF = 8;
  localparam int Q_DEPTH      = 2;
  localparam int ROOT_W       = 17;
  localparam int SQ_W         = 33;
  localparam int ROOT_ITER    = 17;

  localparam logic [11:0] HALF_TURN    = 12'd2880;
  localparam logic [13:0] QUARTER_TURN = 14'd2880;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 12;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_LIMIT  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_DIVISOR = 1'd1;

  localparam logic [11:0] ANGLE_LIMIT_RST  = 12'd160;
  localparam logic [3:0]  SIZE_DIVISOR_RST = 4'd5;

  typedef struct packed {
    logic [15:0] bar_x;
    logic [15:0] bar_y;
    logic [11:0] bar_angle;
    logic [15:0] bar_height;
    logic [15:0] bar_width;
    logic        last_bar;
  } in_item_t;

  typedef struct packed {
    logic        pair_found;
    logic [16:0] armor_x;
    logic [16:0] armor_y;
    logic [13:0] armor_angle;
    logic [12:0] armor_short;
    logic [12:0] armor_long;
    logic [2:0]  first_index;
    logic [2:0]  second_index;
    logic        bars_dropped;
    logic        last_result;
  } out_item_t;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [11:0] angle;
    logic [15:0] height;
    logic [15:0] width;
  } bar_t;

  // classified command handed from front to back
  typedef struct packed {
    bar_t bar;
    logic keep;
    logic last;
    logic dropped;
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_CMP, S_EVAL, S_ROOT, S_STASH, S_NEXT, S_FINAL
  } bk_state_t;

endpackage

// ===== hdl/lbpm_front.sv =====
// Front part of the pair matcher: accepts bars, classifies keep/drop,
// and queues commands for the back part. Depends on lbpm_pkg.
module lbpm_front #(
  parameter int MAX_BARS = lbpm_pkg::MAX_BARS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  lbpm_pkg::in_item_t in_data,
  output logic             q_valid,
  output lbpm_pkg::cmd_t   q_data,
  input  logic             q_pop
);
  import lbpm_pkg::*;

  localparam int CNT_W = $clog2(MAX_BARS + 1);
  localparam int PTR_W = $clog2(Q_DEPTH);
  localparam int QC_W  = $clog2(Q_DEPTH + 1);

  cmd_t             q_mem_r [Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QC_W-1:0]  q_cnt_r;
  logic [CNT_W-1:0] bar_cnt_r;
  logic             ovf_r;
  logic             push, keep;
  cmd_t             cmd;

  assign in_stall = (q_cnt_r == QC_W'(Q_DEPTH));
  assign push     = in_valid && !in_stall;
  assign keep     = (bar_cnt_r < CNT_W'(MAX_BARS));
  assign q_valid  = (q_cnt_r != '0);
  assign q_data   = q_mem_r[rd_ptr_r];

  always_comb begin
    cmd.bar.x      = in_data.bar_x;
    cmd.bar.y      = in_data.bar_y;
    cmd.bar.angle  = in_data.bar_angle;
    cmd.bar.height = in_data.bar_height;
    cmd.bar.width  = in_data.bar_width;
    cmd.keep       = keep;
    cmd.last       = in_data.last_bar;
    cmd.dropped    = ovf_r || !keep;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r  <= '0;
      rd_ptr_r  <= '0;
      q_cnt_r   <= '0;
      bar_cnt_r <= '0;
      ovf_r     <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
        if (in_data.last_bar) begin
          bar_cnt_r <= '0;
          ovf_r     <= 1'b0;
        end else if (keep) begin
          bar_cnt_r <= bar_cnt_r + CNT_W'(1);
        end else begin
          ovf_r <= 1'b1;
        end
      end
      if (q_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      q_cnt_r <= q_cnt_r + QC_W'(push) - QC_W'(q_pop);
    end
  end

endmodule

// ===== hdl/lbpm_isqrt.sv =====
// Iterative integer square root, two radicand bits per cycle.
// Depends on lbpm_pkg.
module lbpm_isqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [lbpm_pkg::SQ_W-1:0]   value,
  output logic                        done,
  output logic [lbpm_pkg::ROOT_W-1:0] root
);
  import lbpm_pkg::*;

  localparam int VAL_W = 2 * ROOT_ITER;
  localparam int REM_W = ROOT_W + 3;
  localparam int IT_W  = $clog2(ROOT_ITER + 1);

  logic [VAL_W-1:0]  val_r;
  logic [REM_W-1:0]  rem_r, rem_nxt, rem_sh, trial;
  logic [ROOT_W-1:0] root_r, root_nxt;
  logic [IT_W-1:0]   it_r;
  logic              busy_r, done_r;

  assign done = done_r;
  assign root = root_r;

  always_comb begin
    rem_sh = {rem_r[REM_W-3:0], val_r[VAL_W-1 -: 2]};
    trial  = {1'b0, root_r, 2'b01};
    if (rem_sh >= trial) begin
      rem_nxt  = rem_sh - trial;
      root_nxt = {root_r[ROOT_W-2:0], 1'b1};
    end else begin
      rem_nxt  = rem_sh;
      root_nxt = {root_r[ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      val_r  <= VAL_W'(value);
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      val_r  <= {val_r[VAL_W-3:0], 2'b00};
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      it_r   <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      it_r   <= IT_W'(ROOT_ITER);
    end else if (busy_r) begin
      it_r <= it_r - IT_W'(1);
      if (it_r == IT_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

endmodule

// ===== hdl/lbpm_back.sv =====
// Back part of the pair matcher: bar store, pair search sequencer,
// result holding and output register. Depends on lbpm_pkg, lbpm_isqrt.
`include "light_bar_pair_matcher_defines.svh"
module lbpm_back #(
  parameter int MAX_BARS = lbpm_pkg::MAX_BARS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  input  lbpm_pkg::cmd_t        q_data,
  output logic                  q_pop,
  input  logic [11:0]           angle_limit,
  input  logic [3:0]            size_divisor,
  output logic                  out_valid,
  input  logic                  out_stall,
  output lbpm_pkg::out_item_t   out_data
);
  import lbpm_pkg::*;

  localparam int CNT_W = $clog2(MAX_BARS + 1);
  localparam int IDX_W = (MAX_BARS > 1) ? $clog2(MAX_BARS) : 1;

  bk_state_t state_r, state_nxt;

  bar_t             mem [MAX_BARS];
  bar_t             rd_a_r, rd_b_r;
  logic [CNT_W-1:0] wr_cnt_r, cnt_r, i_r, j_r;
  logic             ovf_r;

  logic        match_r;
  logic [31:0] sqx_r, sqy_r;
  logic [16:0] sumx_r, sumy_r;
  logic [13:0] ang_r;
  logic [11:0] meanh_r;

  out_item_t pend_r, out_r, new_res, fin_res;
  logic      pend_valid_r, out_valid_r;

  logic out_free, stash_rdy, root_start, out_load, pend_load;
  logic root_done;
  logic [ROOT_W-1:0] root_q;

  // pair tests
  logic [11:0] ang_d0, ang_d;
  logic        par, anti;
  logic [15:0] hd, wd, dx, dy;
  logic [16:0] hs, ws;
  logic [19:0] h_prod, w_prod;
  logic        size_ok;
  logic [12:0] dist_px, meanh13;

  assign out_free  = !out_valid_r || !out_stall;
  assign stash_rdy = !pend_valid_r || out_free;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  lbpm_isqrt u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (root_start),
    .value (SQ_W'(sqx_r) + SQ_W'(sqy_r)),
    .done  (root_done),
    .root  (root_q)
  );

  always_comb begin
    ang_d0  = (rd_a_r.angle > rd_b_r.angle) ? rd_a_r.angle - rd_b_r.angle
                                            : rd_b_r.angle - rd_a_r.angle;
    ang_d   = (ang_d0 > HALF_TURN) ? ang_d0 - HALF_TURN : ang_d0;
    par     = ang_d < angle_limit;
    anti    = (HALF_TURN - ang_d) < angle_limit;
    hd      = (rd_a_r.height > rd_b_r.height) ? rd_a_r.height - rd_b_r.height
                                              : rd_b_r.height - rd_a_r.height;
    wd      = (rd_a_r.width > rd_b_r.width) ? rd_a_r.width - rd_b_r.width
                                            : rd_b_r.width - rd_a_r.width;
    hs      = 17'(rd_a_r.height) + 17'(rd_b_r.height);
    ws      = 17'(rd_a_r.width) + 17'(rd_b_r.width);
    h_prod  = 20'(size_divisor) * 20'(hd);
    w_prod  = 20'(size_divisor) * 20'(wd);
    size_ok = (h_prod < 20'(hs)) && (w_prod < 20'(ws));
    dx      = (rd_a_r.x > rd_b_r.x) ? rd_a_r.x - rd_b_r.x : rd_b_r.x - rd_a_r.x;
    dy      = (rd_a_r.y > rd_b_r.y) ? rd_a_r.y - rd_b_r.y : rd_b_r.y - rd_a_r.y;
  end

  always_comb begin
    dist_px = 13'(root_q >> 4);
    meanh13 = 13'(meanh_r);
    new_res.pair_found   = 1'b1;
    new_res.armor_x      = sumx_r;
    new_res.armor_y      = sumy_r;
    new_res.armor_angle  = ang_r;
    new_res.armor_short  = (meanh13 < dist_px) ? meanh13 : dist_px;
    new_res.armor_long   = (meanh13 < dist_px) ? dist_px : meanh13;
    new_res.first_index  = 3'(i_r);
    new_res.second_index = 3'(j_r);
    new_res.bars_dropped = ovf_r;
    new_res.last_result  = 1'b0;
    if (pend_valid_r) begin
      fin_res = pend_r;
    end else begin
      fin_res = '0;
      fin_res.bars_dropped = ovf_r;
    end
    fin_res.last_result = 1'b1;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (q_valid && q_data.last) begin
          state_nxt = ((wr_cnt_r + CNT_W'(q_data.keep)) < CNT_W'(2)) ? S_FINAL : S_READ;
        end
      end
      S_READ:  state_nxt = S_CMP;
      S_CMP:   state_nxt = S_EVAL;
      S_EVAL:  state_nxt = match_r ? S_ROOT : S_NEXT;
      S_ROOT:  state_nxt = root_done ? S_STASH : S_ROOT;
      S_STASH: state_nxt = stash_rdy ? S_NEXT : S_STASH;
      S_NEXT: begin
        if ((j_r + CNT_W'(1)) < cnt_r || (i_r + CNT_W'(2)) < cnt_r) begin
          state_nxt = S_READ;
        end else begin
          state_nxt = S_FINAL;
        end
      end
      S_FINAL: state_nxt = out_free ? S_IDLE : S_FINAL;
      default: state_nxt = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    q_pop      = 1'b0;
    root_start = 1'b0;
    out_load   = 1'b0;
    pend_load  = 1'b0;
    unique case (state_r)
      S_IDLE:  q_pop = q_valid;
      S_EVAL:  root_start = match_r;
      S_STASH: begin
        pend_load = stash_rdy;
        out_load  = stash_rdy && pend_valid_r;
      end
      S_FINAL: out_load = out_free;
      default: ;
    endcase
  end

  // bar store: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (q_pop && q_data.keep) begin
      mem[wr_cnt_r[IDX_W-1:0]] <= q_data.bar;
    end
    rd_a_r <= mem[i_r[IDX_W-1:0]];
    rd_b_r <= mem[j_r[IDX_W-1:0]];
  end

  // pair datapath
  always_ff @(posedge clk) begin
    if (state_r == S_CMP) begin
      match_r <= (par || anti) && size_ok;
      sqx_r   <= 32'(dx) * 32'(dx);
      sqy_r   <= 32'(dy) * 32'(dy);
      sumx_r  <= 17'(rd_a_r.x) + 17'(rd_b_r.x);
      sumy_r  <= 17'(rd_a_r.y) + 17'(rd_b_r.y);
      ang_r   <= 14'(rd_a_r.angle) + 14'(rd_b_r.angle) + (anti ? QUARTER_TURN : 14'd0);
      meanh_r <= hs[16:5];
    end
    if (pend_load) begin
      pend_r <= new_res;
    end
    if (out_load) begin
      out_r <= (state_r == S_FINAL) ? fin_res : pend_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      wr_cnt_r     <= '0;
      cnt_r        <= '0;
      i_r          <= '0;
      j_r          <= '0;
      ovf_r        <= 1'b0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (q_pop) begin
        if (q_data.last) begin
          cnt_r    <= wr_cnt_r + CNT_W'(q_data.keep);
          wr_cnt_r <= '0;
          ovf_r    <= q_data.dropped;
          i_r      <= '0;
          j_r      <= CNT_W'(1);
        end else if (q_data.keep) begin
          wr_cnt_r <= wr_cnt_r + CNT_W'(1);
        end
      end
      if (state_r == S_NEXT) begin
        if ((j_r + CNT_W'(1)) < cnt_r) begin
          j_r <= j_r + CNT_W'(1);
        end else begin
          i_r <= i_r + CNT_W'(1);
          j_r <= i_r + CNT_W'(2);
        end
      end
      if (pend_load) begin
        pend_valid_r <= 1'b1;
      end else if (state_r == S_FINAL && out_free) begin
        pend_valid_r <= 1'b0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  `LBPM_ASSERT_IMP(a_idle_no_pend, state_r == S_IDLE, !pend_valid_r)
  `LBPM_ASSERT_IMP(a_pair_order, state_r == S_READ, (i_r < j_r) && (j_r < cnt_r))
  `LBPM_ASSERT_NXT(a_final_marks_last, state_r == S_FINAL && out_free, out_valid_r && out_r.last_result)

endmodule

// ===== hdl/light_bar_pair_matcher.sv =====
// Top level of the light-bar pair matcher: config registers, front and back.
// Depends on lbpm_pkg, lbpm_front, lbpm_back.
//
// Usage: feed one fitted light bar per item on in_* (valid/stall). Bars are
// stored until an item with last_bar set arrives; up to MAX_BARS are kept,
// later ones are dropped and flagged in bars_dropped. The last bar starts
// the pair search over all stored pairs (i<j) in ascending order.
// Each matching pair yields one item on out_*; a frame with no match yields
// one empty item. The final item of a frame carries last_result.
// Back part: while idle it stores each non-last bar and pops the next one
// straight away. A search runs READ, CMP, EVAL, NEXT for each pair tested,
// plus ROOT (17-step iterative square root) and STASH for each match.
// A two-entry command queue lets input be accepted during a search.
// A frame with fewer than two bars goes from IDLE straight to FINAL;
// a found pair is held back until the next match or the search end.
// Reset (synchronous, rst_n low) empties the queue and bar count and loads
// angle_limit = 160 and size_divisor = 5. Config writes are taken on cfg_we.
// When out_stall is high the result item holds; the search pauses
// with at most one further result pending, and input stops once the
// queue fills.
module light_bar_pair_matcher #(
  parameter int MAX_BARS = lbpm_pkg::MAX_BARS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  lbpm_pkg::in_item_t               in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output lbpm_pkg::out_item_t              out_data,
  input  logic                             cfg_we,
  input  logic [lbpm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lbpm_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import lbpm_pkg::*;

  logic [11:0] angle_limit_r;
  logic [3:0]  size_div_r;
  logic        q_valid, q_pop;
  cmd_t        q_data;

  // config register decode
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      angle_limit_r <= ANGLE_LIMIT_RST;
      size_div_r    <= SIZE_DIVISOR_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ANGLE_LIMIT:  angle_limit_r <= cfg_wdata[11:0];
        REG_SIZE_DIVISOR: size_div_r    <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  // accept and classify bars
  lbpm_front #(.MAX_BARS(MAX_BARS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_data   (q_data),
    .q_pop    (q_pop)
  );

  // store bars, search pairs, drive results
  lbpm_back #(.MAX_BARS(MAX_BARS)) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_valid      (q_valid),
    .q_data       (q_data),
    .q_pop        (q_pop),
    .angle_limit  (angle_limit_r),
    .size_divisor (size_div_r),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data)
  );

endmodule
